>>> hdl/sast_pkg.sv
package sast_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [31:0] MAGIC_WORD       = 32'h0723_0203;
  localparam logic [2:0]  HEADER_WORDS     = 3'd5;
  localparam logic [15:0] MIN_WORDS        = 16'd4;
  localparam logic [15:0] OP_DECORATE      = 16'd71;
  localparam logic [15:0] OP_TYPE_POINTER  = 16'd32;
  localparam logic [31:0] DEC_ARRAY_STRIDE = 32'd6;
  localparam logic [31:0] SC_PHYS_STORAGE  = 32'd5349;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC  = 3'd1;
  localparam logic [2:0] ST_SHORT_HDR  = 3'd2;
  localparam logic [2:0] ST_MALFORMED  = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_START   = 2'd1,
    MODE_INSIDE  = 2'd2,
    MODE_STOPPED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    RES_KEEP   = 2'd0,
    RES_ZERO   = 2'd1,
    RES_STRIDE = 2'd2
  } res_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic     cap;       // take the input transfer
    logic     parse;     // advance the word parser
    logic     match;     // compare key against held ids
    logic     enc;       // fold match vector into index
    logic     write;     // update or create table entry
    logic     key_ptr;   // next key is the pointee just read
    res_sel_t res_sel;
    logic     load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic action;
    logic fin_req;
    logic hit;
    logic stride_nz;
    logic pointee_nz;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/sast_ram.sv
module sast_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                 wdata,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hdl/sast_dp.sv
module sast_dp
  import sast_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [63:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata
);

  // captured item
  logic        action_r, first_r, last_r;
  logic [31:0] word_r;

  // parser state
  mode_t       mode_r, mode_nxt;
  logic [2:0]  hs_r, hs_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [15:0] wl_r, wl_nxt;
  logic [15:0] op_r, op_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] o1_r, o1_nxt, o2_r, o2_nxt, o3_r, o3_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic        fin_req;
  logic [15:0] pos;

  // lookup / update
  logic [31:0]            key_r;
  logic [31:0]            fin_val_r;
  logic                   fin_is_stride_r;
  logic [31:0]            entry_id_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match_r;
  logic                   hit_r;
  logic [IDX_W-1:0]       idx_r, idx_fold;
  logic                   can_create;
  logic [IDX_W-1:0]       ram_addr;
  logic                   stride_we, pointee_we;
  logic [31:0]            stride_wd, pointee_wd, stride_q, pointee_q;

  // result
  logic [31:0] res_r;
  logic        out_valid_r;
  logic [47:0] out_data_r;

  always_comb begin
    mode_nxt   = mode_r;
    hs_nxt     = hs_r;
    status_nxt = status_r;
    wl_nxt     = wl_r;
    op_nxt     = op_r;
    len_nxt    = len_r;
    o1_nxt     = o1_r;
    o2_nxt     = o2_r;
    o3_nxt     = o3_r;
    used_nxt   = used_r;
    fin_req    = 1'b0;
    pos        = '0;
    if (cmd.parse) begin
      if (first_r) begin
        mode_nxt   = MODE_HEADER;
        hs_nxt     = '0;
        status_nxt = ST_OK;
        wl_nxt     = '0;
        op_nxt     = '0;
        len_nxt    = '0;
        o1_nxt     = '0;
        o2_nxt     = '0;
        o3_nxt     = '0;
        used_nxt   = '0;
      end
      case (mode_nxt)
        MODE_HEADER: begin
          if (hs_nxt == 3'd0 && word_r != MAGIC_WORD) begin
            status_nxt = ST_BAD_MAGIC;
          end
          hs_nxt = hs_nxt + 3'd1;
          if (hs_nxt >= HEADER_WORDS) begin
            hs_nxt   = HEADER_WORDS;
            mode_nxt = (status_nxt == ST_BAD_MAGIC || last_r) ? MODE_STOPPED : MODE_START;
          end else if (last_r) begin
            status_nxt = ST_SHORT_HDR;
            mode_nxt   = MODE_STOPPED;
          end
        end
        MODE_START: begin
          len_nxt = word_r[31:16];
          op_nxt  = word_r[15:0];
          o1_nxt  = '0;
          o2_nxt  = '0;
          o3_nxt  = '0;
          if (len_nxt == 16'd0) begin
            status_nxt = ST_MALFORMED;
            mode_nxt   = MODE_STOPPED;
          end else begin
            wl_nxt = len_nxt - 16'd1;
            // one-word instructions are too short to record anything
            if (wl_nxt == 16'd0) begin
              mode_nxt = last_r ? MODE_STOPPED : MODE_START;
            end else if (last_r) begin
              status_nxt = ST_MALFORMED;
              mode_nxt   = MODE_STOPPED;
            end else begin
              mode_nxt = MODE_INSIDE;
            end
          end
        end
        MODE_INSIDE: begin
          pos = len_nxt - wl_nxt;
          if (pos == 16'd1) begin
            o1_nxt = word_r;
          end else if (pos == 16'd2) begin
            o2_nxt = word_r;
          end else if (pos == 16'd3) begin
            o3_nxt = word_r;
          end
          wl_nxt = wl_nxt - 16'd1;
          if (wl_nxt == 16'd0) begin
            fin_req = (len_nxt >= MIN_WORDS) &&
                      ((op_nxt == OP_DECORATE && o2_nxt == DEC_ARRAY_STRIDE) ||
                       (op_nxt == OP_TYPE_POINTER && o2_nxt == SC_PHYS_STORAGE));
            mode_nxt = last_r ? MODE_STOPPED : MODE_START;
          end else if (last_r) begin
            status_nxt = ST_MALFORMED;
            mode_nxt   = MODE_STOPPED;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.write) begin
      if (!hit_r) begin
        if (can_create) begin
          used_nxt = used_r + CNT_W'(1);
        end else if (status_r == ST_OK) begin
          status_nxt = ST_TABLE_FULL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_HEADER;
      hs_r     <= '0;
      status_r <= ST_OK;
      wl_r     <= '0;
      op_r     <= '0;
      len_r    <= '0;
      o1_r     <= '0;
      o2_r     <= '0;
      o3_r     <= '0;
      used_r   <= '0;
    end else begin
      mode_r   <= mode_nxt;
      hs_r     <= hs_nxt;
      status_r <= status_nxt;
      wl_r     <= wl_nxt;
      op_r     <= op_nxt;
      len_r    <= len_nxt;
      o1_r     <= o1_nxt;
      o2_r     <= o2_nxt;
      o3_r     <= o3_nxt;
      used_r   <= used_nxt;
    end
  end

  assign can_create = used_r < CNT_W'(TABLE_DEPTH);

  always_comb begin
    idx_fold = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (match_r[i]) begin
        idx_fold = idx_fold | IDX_W'(i);
      end
    end
  end

  // ids are unique among held entries, so at most one match bit is set
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      action_r <= in_tuser[0];
      first_r  <= in_tuser[1];
      last_r   <= in_tlast;
      word_r   <= in_tdata[31:0];
      key_r    <= in_tdata[63:32];
    end else if (cmd.parse) begin
      key_r <= o1_nxt;
    end else if (cmd.key_ptr) begin
      key_r <= pointee_q;
    end
    if (cmd.parse) begin
      fin_val_r       <= o3_nxt;
      fin_is_stride_r <= (op_nxt == OP_DECORATE);
    end
    if (cmd.match) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        match_r[i] <= (entry_id_r[i] == key_r) && (CNT_W'(i) < used_r);
      end
    end
    if (cmd.enc) begin
      hit_r <= |match_r;
      idx_r <= idx_fold;
    end
    if (cmd.write && !hit_r && can_create) begin
      entry_id_r[used_r[IDX_W-1:0]] <= key_r;
    end
    case (cmd.res_sel)
      RES_ZERO:   res_r <= '0;
      RES_STRIDE: res_r <= stride_q;
      default:    res_r <= res_r;
    endcase
  end

  assign ram_addr   = (cmd.write && !hit_r) ? used_r[IDX_W-1:0] : idx_r;
  assign stride_we  = cmd.write && (hit_r ? fin_is_stride_r : can_create);
  assign pointee_we = cmd.write && (hit_r ? !fin_is_stride_r : can_create);
  assign stride_wd  = fin_is_stride_r ? fin_val_r : 32'd0;
  assign pointee_wd = fin_is_stride_r ? 32'd0 : fin_val_r;

  sast_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_stride_ram (
    .clk   (clk),
    .we    (stride_we),
    .addr  (ram_addr),
    .wdata (stride_wd),
    .rdata (stride_q)
  );

  sast_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_pointee_ram (
    .clk   (clk),
    .we    (pointee_we),
    .addr  (ram_addr),
    .wdata (pointee_wd),
    .rdata (pointee_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {7'd0, 6'(used_r), status_r, res_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sts.action     = action_r;
  assign sts.fin_req    = fin_req;
  assign sts.hit        = hit_r;
  assign sts.stride_nz  = (stride_q != 32'd0);
  assign sts.pointee_nz = (pointee_q != 32'd0);
  assign sts.out_free   = !out_valid_r || out_tready;

endmodule

>>> hdl/sast_ctrl.sv
module sast_ctrl
  import sast_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_PARSE   = 14'b00000000000010,
    S_F_MATCH = 14'b00000000000100,
    S_F_ENC   = 14'b00000000001000,
    S_F_WRITE = 14'b00000000010000,
    S_Q_MATCH = 14'b00000000100000,
    S_Q_ENC   = 14'b00000001000000,
    S_Q_READ  = 14'b00000010000000,
    S_Q_CHK   = 14'b00000100000000,
    S_P_MATCH = 14'b00001000000000,
    S_P_ENC   = 14'b00010000000000,
    S_P_READ  = 14'b00100000000000,
    S_P_CHK   = 14'b01000000000000,
    S_RESP    = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_PARSE;
        end
      end
      S_PARSE: begin
        // a query skips the parser and goes straight to the lookup
        if (sts.action) begin
          cmd.match = 1'b1;
          state_nxt = S_Q_ENC;
        end else begin
          cmd.parse   = 1'b1;
          cmd.res_sel = RES_ZERO;
          state_nxt   = sts.fin_req ? S_F_MATCH : S_RESP;
        end
      end
      S_F_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = S_F_ENC;
      end
      S_F_ENC: begin
        cmd.enc   = 1'b1;
        state_nxt = S_F_WRITE;
      end
      S_F_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_RESP;
      end
      S_Q_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = S_Q_ENC;
      end
      S_Q_ENC: begin
        cmd.enc   = 1'b1;
        state_nxt = S_Q_READ;
      end
      S_Q_READ: begin
        if (sts.hit) begin
          state_nxt = S_Q_CHK;
        end else begin
          cmd.res_sel = RES_ZERO;
          state_nxt   = S_RESP;
        end
      end
      S_Q_CHK: begin
        if (sts.stride_nz) begin
          cmd.res_sel = RES_STRIDE;
          state_nxt   = S_RESP;
        end else if (sts.pointee_nz) begin
          cmd.key_ptr = 1'b1;
          state_nxt   = S_P_MATCH;
        end else begin
          cmd.res_sel = RES_ZERO;
          state_nxt   = S_RESP;
        end
      end
      S_P_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = S_P_ENC;
      end
      S_P_ENC: begin
        cmd.enc   = 1'b1;
        state_nxt = S_P_READ;
      end
      S_P_READ: begin
        if (sts.hit) begin
          state_nxt = S_P_CHK;
        end else begin
          cmd.res_sel = RES_ZERO;
          state_nxt   = S_RESP;
        end
      end
      S_P_CHK: begin
        cmd.res_sel = RES_STRIDE;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/spirv_array_stride_table.sv
// Scans a SPIR-V module one word per transfer (header check, instruction split) and keeps a
// table of ArrayStride decorations and PhysicalStorageBuffer pointee ids, up to TABLE_DEPTH
// ids; a query transfer returns the stride of an id or of its pointee. One item is worked at
// a time and every item gives one result. A module word that closes a recorded instruction
// also takes an id compare across the table, an index fold and a RAM write. A query whose
// id is held with no stride of its own but with a pointee follows that pointee with a second
// lookup; each lookup is a registered compare over all held ids, a fold to an index and a
// RAM read. The next input is taken while a result waits in the output register; an item
// that is done waits until the result before it has been taken on out_tready.
module spirv_array_stride_table
  import sast_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // module_word[31:0], query_id[63:32]
  input  logic [1:0]  in_tuser,   // action[0], first_of_module[1]
  input  logic        in_tlast,   // last_of_module
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // stride_bytes[31:0], status[34:32], entries_in_use[40:35]
);

  cmd_t cmd;
  sts_t sts;

  sast_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sast_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> tb/spirv_array_stride_table_checker.sv
module spirv_array_stride_table_checker
  import sast_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // module_word[31:0], query_id[63:32]
  input  logic [1:0]  in_tuser,   // action[0], first_of_module[1]
  input  logic        in_tlast,   // last_of_module
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // stride_bytes[31:0], status[34:32], entries_in_use[40:35]
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] stride;
    logic [2:0]  status;
    logic [5:0]  entries;
  } stride_result_t;

  stride_result_t stride_results_due[$];

  // shadow of the id table and the word parser
  logic [31:0] id_mem      [TABLE_DEPTH];
  logic [31:0] stride_mem  [TABLE_DEPTH];
  logic [31:0] pointee_mem [TABLE_DEPTH];
  int unsigned n_used;
  int unsigned hdr_count;
  mode_t       mode;
  logic [2:0]  mstat;
  logic [15:0] owed;
  logic [15:0] opc;
  logic [15:0] ilen;
  logic [31:0] opnd1;
  logic [31:0] opnd2;
  logic [31:0] opnd3;

  task automatic wipe_table();
    n_used    = 0;
    hdr_count = 0;
    mode      = MODE_HEADER;
    mstat     = ST_OK;
    owed      = '0;
    opc       = '0;
    ilen      = '0;
    opnd1     = '0;
    opnd2     = '0;
    opnd3     = '0;
  endtask

  function automatic int find_slot(input logic [31:0] id);
    for (int i = 0; i < n_used; i++) begin
      if (id_mem[i] == id) return i;
    end
    return -1;
  endfunction

  // existing entry, or a fresh one; a full table drops the id
  function automatic int claim_slot(input logic [31:0] id);
    int k;
    k = find_slot(id);
    if (k >= 0) return k;
    if (n_used >= TABLE_DEPTH) begin
      if (mstat == ST_OK) mstat = ST_TABLE_FULL;
      return -1;
    end
    k = n_used;
    id_mem[k]      = id;
    stride_mem[k]  = '0;
    pointee_mem[k] = '0;
    n_used++;
    return k;
  endfunction

  task automatic close_instr();
    int k;
    if (ilen < MIN_WORDS) return;
    if (opc == OP_DECORATE && opnd2 == DEC_ARRAY_STRIDE) begin
      k = claim_slot(opnd1);
      if (k >= 0) stride_mem[k] = opnd3;
    end else if (opc == OP_TYPE_POINTER && opnd2 == SC_PHYS_STORAGE) begin
      k = claim_slot(opnd1);
      if (k >= 0) pointee_mem[k] = opnd3;
    end
  endtask

  task automatic absorb_word(input logic [31:0] w, input logic last);
    logic [15:0] pos;
    case (mode)
      MODE_HEADER: begin
        if (hdr_count == 0 && w != MAGIC_WORD) mstat = ST_BAD_MAGIC;
        hdr_count++;
        if (hdr_count >= HEADER_WORDS) begin
          hdr_count = HEADER_WORDS;
          mode = (mstat == ST_BAD_MAGIC || last) ? MODE_STOPPED : MODE_START;
        end else if (last) begin
          mstat = ST_SHORT_HDR;
          mode  = MODE_STOPPED;
        end
      end
      MODE_START: begin
        ilen  = w[31:16];
        opc   = w[15:0];
        opnd1 = '0;
        opnd2 = '0;
        opnd3 = '0;
        if (ilen == 16'd0) begin
          mstat = ST_MALFORMED;
          mode  = MODE_STOPPED;
        end else begin
          owed = ilen - 16'd1;
          if (owed == 16'd0) begin
            close_instr();
            mode = last ? MODE_STOPPED : MODE_START;
          end else if (last) begin
            mstat = ST_MALFORMED;
            mode  = MODE_STOPPED;
          end else begin
            mode = MODE_INSIDE;
          end
        end
      end
      MODE_INSIDE: begin
        pos = ilen - owed;
        if (pos == 16'd1) opnd1 = w;
        else if (pos == 16'd2) opnd2 = w;
        else if (pos == 16'd3) opnd3 = w;
        owed = owed - 16'd1;
        if (owed == 16'd0) begin
          close_instr();
          mode = last ? MODE_STOPPED : MODE_START;
        end else if (last) begin
          mstat = ST_MALFORMED;
          mode  = MODE_STOPPED;
        end
      end
      default: ;
    endcase
  endtask

  // own stride first, then the pointee's
  function automatic logic [31:0] resolve_stride(input logic [31:0] id);
    int k;
    int p;
    k = find_slot(id);
    if (k < 0) return '0;
    if (stride_mem[k] != '0) return stride_mem[k];
    if (pointee_mem[k] != '0) begin
      p = find_slot(pointee_mem[k]);
      if (p >= 0) return stride_mem[p];
    end
    return '0;
  endfunction

  always @(posedge clk) begin
    stride_result_t want;
    if (!rst_n) begin
      wipe_table();
      stride_results_due.delete();
      pending = 0;
    end else begin
      // results first, so a transfer can never match the item taken at the same edge
      if (out_tvalid && out_tready) begin
        if (stride_results_due.size() == 0) begin
          $error("result transfer with no result due: %h", out_tdata);
          fail_count++;
        end else begin
          want = stride_results_due.pop_front();
          pending--;
          if (out_tdata[31:0] !== want.stride) begin
            $error("stride_bytes: expected %0d, got %0d", want.stride, out_tdata[31:0]);
            fail_count++;
          end
          if (out_tdata[34:32] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tdata[34:32]);
            fail_count++;
          end
          if (out_tdata[40:35] !== want.entries) begin
            $error("entries_in_use: expected %0d, got %0d", want.entries, out_tdata[40:35]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want.stride = '0;
        if (in_tuser[0]) begin
          want.stride = resolve_stride(in_tdata[63:32]);
        end else begin
          if (in_tuser[1]) wipe_table();
          absorb_word(in_tdata[31:0], in_tlast);
        end
        want.status  = mstat;
        want.entries = 6'(n_used);
        stride_results_due.insert(stride_results_due.size(), want);
        pending++;
      end
    end
  end

endmodule

>>> tb/tb_spirv_array_stride_table.sv
module tb_spirv_array_stride_table;
  import sast_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 650;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;   // module_word[31:0], query_id[63:32]
  logic [1:0]  in_tuser   = '0;   // action[0], first_of_module[1]
  logic        in_tlast   = 1'b0; // last_of_module
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // stride_bytes[31:0], status[34:32], entries_in_use[40:35]

  int          fail_count;
  int          pending;
  bit          calm = 1'b0;
  int          sent = 0;
  int          noise = 0;
  int          cycles = 0;
  logic [31:0] mod_words[$];

  always #2 clk = ~clk;

  spirv_array_stride_table uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  spirv_array_stride_table_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= calm || ($urandom_range(99) >= 14);
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ready is looked at on the falling edge, so the transfer edge is known without a race
  task automatic put_item(input bit act, input logic [31:0] word, input bit first,
                          input bit last, input logic [31:0] qid);
    while (!calm && $urandom_range(99) < 14) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {qid, word};
    in_tuser  <= {first, act};
    in_tlast  <= last;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  task automatic send_word(input logic [31:0] w, input bit first, input bit last);
    put_item(1'b0, w, first, last, $urandom());
  endtask

  task automatic send_query(input logic [31:0] id);
    put_item(1'b1, $urandom(), 1'($urandom_range(1)), 1'($urandom_range(1)), id);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 12);
    if (r < 88) return '0;
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_query_id();
    int r;
    r = $urandom_range(99);
    if (r < 60) return pick_id();
    if (r < 85) return 1000 + $urandom_range(0, 40);
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_stride();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 25) return $urandom();
    return 4 * $urandom_range(1, 64);
  endfunction

  task automatic append_word(input logic [31:0] w);
    mod_words.insert(mod_words.size(), w);
  endtask

  task automatic add_instr(input logic [15:0] op, input logic [15:0] len,
                           input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    append_word({len, op});
    for (int i = 1; i < len; i++) begin
      if (i == 1) append_word(a);
      else if (i == 2) append_word(b);
      else if (i == 3) append_word(c);
      else append_word($urandom());
    end
  endtask

  // big: distinct ids past the table depth, some pointers chained to the previous id
  task automatic build_module(input int n_instr, input bit big);
    int          r;
    int          k;
    logic [15:0] len;
    mod_words.delete();
    append_word((!big && $urandom_range(9) == 0) ? $urandom() : MAGIC_WORD);
    repeat (4) append_word($urandom());
    if (!big && $urandom_range(13) == 0) begin
      k = $urandom_range(1, 4);
      while (mod_words.size() > k) void'(mod_words.pop_back());
      return;
    end
    for (int i = 0; i < n_instr; i++) begin
      if (big) begin
        if (i % 3 == 2) add_instr(OP_TYPE_POINTER, 16'd4, 1000 + i, SC_PHYS_STORAGE, 999 + i);
        else add_instr(OP_DECORATE, 16'd4, 1000 + i, DEC_ARRAY_STRIDE,
                       4 * $urandom_range(1, 64));
      end else begin
        r = $urandom_range(99);
        if (r < 30)
          add_instr(OP_DECORATE, 16'($urandom_range(4, 6)), pick_id(), DEC_ARRAY_STRIDE,
                    pick_stride());
        else if (r < 55)
          add_instr(OP_TYPE_POINTER, 16'($urandom_range(4, 5)), pick_id(), SC_PHYS_STORAGE,
                    pick_id());
        else if (r < 65)
          add_instr(OP_DECORATE, 16'($urandom_range(3, 5)), pick_id(), $urandom_range(0, 47),
                    $urandom());
        else if (r < 72)
          add_instr(OP_TYPE_POINTER, 16'd4, pick_id(), $urandom_range(0, 12), pick_id());
        else if (r < 80)
          add_instr($urandom_range(1) ? OP_DECORATE : OP_TYPE_POINTER,
                    16'($urandom_range(1, 3)),
                    pick_id(), $urandom_range(1) ? DEC_ARRAY_STRIDE : SC_PHYS_STORAGE,
                    pick_stride());
        else
          add_instr(16'($urandom()), 16'($urandom_range(1, 6)), $urandom(), $urandom(),
                    $urandom());
      end
    end
    r = $urandom_range(99);
    if (r < 8 || (big && r < 50)) begin
      // zero word count, then a record that must not land
      append_word({16'd0, 16'($urandom())});
      add_instr(OP_DECORATE, 16'd4, pick_id(), DEC_ARRAY_STRIDE, pick_stride());
    end else if (r < 18) begin
      // module cut short inside an instruction
      len = 16'($urandom_range(2, 65535));
      append_word({len, 16'($urandom())});
      k = $urandom_range(0, (len - 16'd2 < 16'd3) ? len - 16'd2 : 3);
      repeat (k) append_word($urandom());
    end
  endtask

  task automatic send_module();
    for (int i = 0; i < mod_words.size(); i++) begin
      if ($urandom_range(99) < 20) send_query(pick_query_id());
      send_word(mod_words[i], i == 0, i == mod_words.size() - 1);
    end
    // trailing words after the end are dropped by the parser
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_word($urandom(), 1'b0, 1'($urandom_range(1)));
        noise++;
      end
    end
  endtask

  initial begin
    int mod_idx;
    bit big;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // module without a first mark, straight after reset
    send_word(MAGIC_WORD, 1'b0, 1'b0);
    send_word(32'h0001_0600, 1'b0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_word(32'h0000_0040, 1'b0, 1'b0);
    send_word(32'h0000_0000, 1'b0, 1'b0);
    send_word({16'd4, OP_DECORATE}, 1'b0, 1'b0);
    send_word(32'd10, 1'b0, 1'b0);
    send_word(DEC_ARRAY_STRIDE, 1'b0, 1'b0);
    send_word(32'd16, 1'b0, 1'b0);
    send_word({16'd4, OP_TYPE_POINTER}, 1'b0, 1'b0);
    send_word(32'd20, 1'b0, 1'b0);
    send_word(SC_PHYS_STORAGE, 1'b0, 1'b0);
    send_word(32'd10, 1'b0, 1'b0);
    send_word({16'd1, 16'hFFFF}, 1'b0, 1'b0);
    // zero word count stops parsing, table is kept
    send_word({16'd0, OP_DECORATE}, 1'b0, 1'b0);
    send_query(32'd10);
    send_query(32'd20);
    send_query(32'hFFFF_FFFF);
    send_word({16'd4, OP_DECORATE}, 1'b0, 1'b1);
    // bad magic, full header
    send_word(32'h0000_0000, 1'b1, 1'b0);
    repeat (3) send_word($urandom(), 1'b0, 1'b0);
    send_word($urandom(), 1'b0, 1'b1);
    // short header
    send_word(MAGIC_WORD, 1'b1, 1'b0);
    send_word($urandom(), 1'b0, 1'b1);
    send_query(32'd0);

    drain();
    sent = 0;
    mod_idx = 0;
    while (sent - noise < RANDOM_ITEMS) begin
      calm = (mod_idx >= 6 && mod_idx < 9);
      big  = (mod_idx == 3) || ($urandom_range(19) == 0);
      build_module(big ? TABLE_DEPTH + $urandom_range(2, 6) : $urandom_range(2, 10), big);
      send_module();
      if (mod_idx == 5) drain();
      mod_idx++;
    end
    calm = 1'b0;

    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (24) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
